// ----- rtl/sga_pkg.sv -----
`timescale 1ns / 1ps

package sga_pkg;

  localparam int unsigned IDX_W   = 20;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SQRT_N  = 34;
  localparam int unsigned DIV_N   = 104;

  localparam logic [67:0]  E2_Q32     = 68'd42949673;
  localparam logic [100:0] E2_Q48     = 101'd2814749767107;
  localparam logic [48:0]  TERM_CLAMP = 49'h1_0000_0000_0000;

  localparam logic [1:0] REG_TGT_INDEX = 2'd0;
  localparam logic [1:0] REG_TGT_X     = 2'd1;
  localparam logic [1:0] REG_TGT_Y     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MXX,
    ST_MYY,
    ST_SQRT,
    ST_MRR,
    ST_MRRR,
    ST_MNX,
    ST_DIVX,
    ST_MNY,
    ST_DIVY,
    ST_FIN
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   first;
    logic   load;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic self_hit;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/sga_ctrl.sv -----
`timescale 1ns / 1ps

module sga_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sga_pkg::status_t status,
  output sga_pkg::cmd_t   cmd
);

  sga_pkg::state_t state, state_next;
  logic            first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sga_pkg::ST_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= (state_next != state);
    end
  end

  always_comb begin
    state_next = state;
    cmd.phase  = state;
    cmd.first  = first;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    in_stall   = (state != sga_pkg::ST_IDLE);
    case (state)
      sga_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.self_hit ? sga_pkg::ST_FIN : sga_pkg::ST_MXX;
        end
      end
      sga_pkg::ST_MXX:  if (status.done) state_next = sga_pkg::ST_MYY;
      sga_pkg::ST_MYY:  if (status.done) state_next = sga_pkg::ST_SQRT;
      sga_pkg::ST_SQRT: if (status.done) state_next = sga_pkg::ST_MRR;
      sga_pkg::ST_MRR:  if (status.done) state_next = sga_pkg::ST_MRRR;
      sga_pkg::ST_MRRR: if (status.done) state_next = sga_pkg::ST_MNX;
      sga_pkg::ST_MNX:  if (status.done) state_next = sga_pkg::ST_DIVX;
      sga_pkg::ST_DIVX: if (status.done) state_next = sga_pkg::ST_MNY;
      sga_pkg::ST_MNY:  if (status.done) state_next = sga_pkg::ST_DIVY;
      sga_pkg::ST_DIVY: if (status.done) state_next = sga_pkg::ST_FIN;
      sga_pkg::ST_FIN: begin
        if (!status.last) begin
          state_next = sga_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sga_pkg::ST_IDLE;
        end
      end
      default: state_next = sga_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sga_datapath.sv -----
`timescale 1ns / 1ps

module sga_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [1:0]             wr_index,
  input  logic [31:0]            wr_data,
  input  logic [19:0]            body_index,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  input  logic [31:0]            mass,
  input  logic                   last,
  input  sga_pkg::cmd_t          cmd,
  output sga_pkg::status_t       status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [47:0]     accel_x,
  output logic signed [47:0]     accel_y,
  output logic                   saturated
);

  function automatic logic [48:0] sat_sum(input logic signed [47:0] acc,
                                          input logic [48:0] qmag,
                                          input logic neg);
    logic signed [50:0] t;
    logic signed [50:0] v;
    logic [48:0] res;
    t = neg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    v = {{3{acc[47]}}, acc} + t;
    if (v > 51'sd140737488355327) begin
      res = {1'b1, 48'h7FFF_FFFF_FFFF};
    end else if (v < -51'sd140737488355328) begin
      res = {1'b1, 48'h8000_0000_0000};
    end else begin
      res = {1'b0, v[47:0]};
    end
    return res;
  endfunction

  logic [19:0]        tgt_index;
  logic signed [31:0] tgt_x, tgt_y;
  logic [32:0]        ax, ay;
  logic               sx, sy;
  logic [31:0]        mass_r;
  logic               last_r;
  logic [101:0]       ma, prod;
  logic [33:0]        mb;
  logic [67:0]        s, srad, r2;
  logic [35:0]        srem;
  logic [33:0]        root;
  logic [100:0]       den, drem;
  logic [103:0]       nsh;
  logic [48:0]        q;
  logic               ovf;
  logic [6:0]         cnt;
  logic signed [47:0] sum_x, sum_y;
  logic               sat_flag;

  logic signed [32:0] dx, dy;
  logic [37:0]        srem2, strial;
  logic               sge;
  logic [101:0]       dt;
  logic               dge;
  logic [48:0]        qmag;
  logic [48:0]        acc_res;
  logic               is_mul, done;

  assign dx = $signed({pos_x[31], pos_x}) - $signed({tgt_x[31], tgt_x});
  assign dy = $signed({pos_y[31], pos_y}) - $signed({tgt_y[31], tgt_y});

  assign srem2  = {srem, srad[67:66]};
  assign strial = {2'b00, root, 2'b01};
  assign sge    = (srem2 >= strial);
  assign dt     = {drem, nsh[103]};
  assign dge    = (dt >= {1'b0, den});
  assign qmag   = (ovf || q > sga_pkg::TERM_CLAMP) ? sga_pkg::TERM_CLAMP : q;
  assign acc_res = (cmd.phase == sga_pkg::ST_DIVX) ? sat_sum(sum_x, qmag, sx)
                                                   : sat_sum(sum_y, qmag, sy);

  assign is_mul = (cmd.phase == sga_pkg::ST_MXX) || (cmd.phase == sga_pkg::ST_MYY)
               || (cmd.phase == sga_pkg::ST_MRR) || (cmd.phase == sga_pkg::ST_MRRR)
               || (cmd.phase == sga_pkg::ST_MNX) || (cmd.phase == sga_pkg::ST_MNY);
  assign done   = !cmd.first && (is_mul ? (mb == '0) : (cnt == '0));

  assign status.done     = done;
  assign status.self_hit = (body_index == tgt_index);
  assign status.last     = last_r;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_index <= '0;
      tgt_x     <= '0;
      tgt_y     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        sga_pkg::REG_TGT_INDEX: tgt_index <= wr_data[19:0];
        sga_pkg::REG_TGT_X:     tgt_x     <= wr_data;
        sga_pkg::REG_TGT_Y:     tgt_y     <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) last_r <= last;
      if (done && cmd.phase == sga_pkg::ST_DIVX) begin
        sum_x <= acc_res[47:0];
        if (acc_res[48]) sat_flag <= 1'b1;
      end
      if (done && cmd.phase == sga_pkg::ST_DIVY) begin
        sum_y <= acc_res[47:0];
        if (acc_res[48]) sat_flag <= 1'b1;
      end
      if (cmd.emit) begin
        sum_x     <= '0;
        sum_y     <= '0;
        sat_flag  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      accel_x   <= sum_x;
      accel_y   <= sum_y;
      saturated <= sat_flag;
    end
    if (cmd.load) begin
      ax     <= dx[32] ? 33'(-dx) : 33'(dx);
      ay     <= dy[32] ? 33'(-dy) : 33'(dy);
      sx     <= dx[32];
      sy     <= dy[32];
      mass_r <= mass;
    end
    if (is_mul) begin
      if (cmd.first) begin
        prod <= '0;
        case (cmd.phase)
          sga_pkg::ST_MXX:  begin ma <= {69'b0, ax};      mb <= {1'b0, ax}; end
          sga_pkg::ST_MYY:  begin ma <= {69'b0, ay};      mb <= {1'b0, ay}; end
          sga_pkg::ST_MRR:  begin ma <= {68'b0, root};    mb <= root;       end
          sga_pkg::ST_MRRR: begin ma <= {34'b0, r2};      mb <= root;       end
          sga_pkg::ST_MNX:  begin ma <= {70'b0, mass_r};  mb <= {1'b0, ax}; end
          default:          begin ma <= {70'b0, mass_r};  mb <= {1'b0, ay}; end
        endcase
      end else if (mb != '0) begin
        if (mb[0]) prod <= prod + ma;
        ma <= {ma[100:0], 1'b0};
        mb <= {1'b0, mb[33:1]};
      end
    end
    if (done) begin
      case (cmd.phase)
        sga_pkg::ST_MXX:  s   <= prod[67:0];
        sga_pkg::ST_MYY:  s   <= s + prod[67:0] + sga_pkg::E2_Q32;
        sga_pkg::ST_MRR:  r2  <= prod[67:0];
        sga_pkg::ST_MRRR: den <= prod[100:0] + sga_pkg::E2_Q48;
        default: ;
      endcase
    end
    if (cmd.phase == sga_pkg::ST_SQRT) begin
      if (cmd.first) begin
        srad <= s;
        srem <= '0;
        root <= '0;
        cnt  <= 7'(sga_pkg::SQRT_N);
      end else if (cnt != '0) begin
        srem <= sge ? 36'(srem2 - strial) : srem2[35:0];
        root <= {root[32:0], sge};
        srad <= {srad[65:0], 2'b00};
        cnt  <= cnt - 7'd1;
      end
    end
    if (cmd.phase == sga_pkg::ST_DIVX || cmd.phase == sga_pkg::ST_DIVY) begin
      if (cmd.first) begin
        nsh  <= {prod[63:0], 40'b0};
        drem <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= 7'(sga_pkg::DIV_N);
      end else if (cnt != '0) begin
        drem <= dge ? 101'(dt - {1'b0, den}) : dt[100:0];
        nsh  <= {nsh[102:0], 1'b0};
        q    <= {q[47:0], dge};
        ovf  <= ovf | q[48];
        cnt  <= cnt - 7'd1;
      end
    end
  end

endmodule

// ----- rtl/softened_gravity_accumulator.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Beat
// in       input      in_valid/in_stall  body_index, pos_x, pos_y, mass, last
// out      output     out_valid/out_stall accel_x, accel_y, saturated
// wr       input      wr_en              wr_index, wr_data
//
// One body at a time; the next is accepted only after the last is through:
// the accept step, six shift-add multiplies (one multiplier bit a cycle),
// a square root, two divides and a finish step. A self body goes straight
// from acceptance to the finish step. Reset is synchronous and clears sums,
// target registers and control state. A stalled result stays in the output
// register; bodies go on until the next last body, whose finish then waits.

module softened_gravity_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        body_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [31:0]        mass,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] accel_x,
  output logic signed [47:0] accel_y,
  output logic               saturated
);

  sga_pkg::cmd_t    cmd;
  sga_pkg::status_t status;

  sga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sga_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .body_index (body_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .mass       (mass),
    .last       (last),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .saturated  (saturated)
  );

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !status.self_hit |=> in_stall)
    else $error("body accepted without starting work");

  a_emit_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised outside finish step");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free && status.last)
    else $error("result overwrote a waiting beat");

endmodule
